// ===== hw/rtl/mfb_pkg.sv =====
// ----------------------------------------------------------------------------
// mfb_pkg
// shared types and constants for the monochrome frame buffer core
// ----------------------------------------------------------------------------
package mfb_pkg;

  localparam int SCREEN_WIDTH_DEF  = 360;
  localparam int SCREEN_HEIGHT_DEF = 160;

  // signed width for mapped coordinates, covers widths up to 2047
  localparam int MAP_W    = 12;
  localparam int ORIENT_W = 2;

  // action codes
  localparam logic [1:0] ACT_DRAW  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_FLUSH = 2'd2;

  // rotation codes
  localparam logic [ORIENT_W-1:0] ROT_0   = 2'd0;
  localparam logic [ORIENT_W-1:0] ROT_90  = 2'd1;
  localparam logic [ORIENT_W-1:0] ROT_180 = 2'd2;
  localparam logic [ORIENT_W-1:0] ROT_270 = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic [8:0] pixel_x;
    logic [8:0] pixel_y;
    logic       pixel_color;
  } in_beat_t;

  typedef struct packed {
    logic       read_value;
    logic [7:0] out_byte;
    logic       group_last;
    logic       frame_done;
    logic       flush_idle;
  } out_beat_t;

  typedef enum logic [1:0] {
    OUT_READ,
    OUT_IDLE,
    OUT_BYTE
  } out_kind_t;

  typedef struct packed {
    logic      take_item;
    logic      do_map;
    logic      do_addr;
    logic      fl_addr;
    logic      mem_rd;
    logic      mem_wr_pix;
    logic      fl_take;
    logic      clr_step;
    logic      out_load;
    out_kind_t out_kind;
    logic      fl_advance;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       map_ok;
    logic       dirty;
    logic       clr_last;
    logic       out_free;
    logic       fetch_last;
    logic       beat_last;
  } dp_status_t;

endpackage

// ===== hw/rtl/mfb_dp.sv =====
// ----------------------------------------------------------------------------
// mfb_dp
// frame store, coordinate mapping, flush unpacking and output register
// ----------------------------------------------------------------------------
module mfb_dp #(
  parameter int SCREEN_WIDTH  = mfb_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = mfb_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mfb_pkg::in_beat_t             in_data,
  input  logic                          cfg_wr_en,
  input  logic [mfb_pkg::ORIENT_W-1:0]  cfg_wr_data,
  input  mfb_pkg::dp_cmd_t              cmd,
  output mfb_pkg::dp_status_t           status,
  output logic                          out_valid,
  input  logic                          out_stall,
  output mfb_pkg::out_beat_t            out_data
);
  import mfb_pkg::*;

  localparam int ROW_BYTES   = (SCREEN_WIDTH + 7) / 8;
  localparam int ROW_GROUPS  = (ROW_BYTES + 2) / 3;
  localparam int STORE_BYTES = ROW_BYTES * SCREEN_HEIGHT;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int XW          = $clog2(SCREEN_WIDTH);
  localparam int YW          = $clog2(SCREEN_HEIGHT);
  localparam int GW          = $clog2(ROW_GROUPS + 1);
  localparam int CW          = $clog2(ROW_BYTES + 3);

  localparam logic signed [MAP_W-1:0] W_S = MAP_W'(SCREEN_WIDTH);
  localparam logic signed [MAP_W-1:0] H_S = MAP_W'(SCREEN_HEIGHT);
  localparam logic signed [MAP_W-1:0] ONE_S = MAP_W'(1);
  localparam logic [AW-1:0] RB_A       = AW'(ROW_BYTES);
  localparam logic [AW-1:0] LAST_ADDR  = AW'(STORE_BYTES - 1);
  localparam logic [CW-1:0] RB_C       = CW'(ROW_BYTES);
  localparam logic [CW-1:0] THREE_C    = CW'(3);
  localparam logic [YW-1:0] LAST_ROW   = YW'(SCREEN_HEIGHT - 1);
  localparam logic [GW-1:0] LAST_GROUP = GW'(ROW_GROUPS - 1);

  logic [7:0] mem [STORE_BYTES];

  in_beat_t               item_r;
  logic [ORIENT_W-1:0]    orient_r;
  logic [XW-1:0]          sx_r;
  logic [YW-1:0]          sy_r;
  logic                   ok_r;
  logic [AW-1:0]          addr_r;
  logic [7:0]             rdata_r;
  logic [23:0]            bits_r;
  logic [CW-1:0]          col_r;
  logic [1:0]             fcnt_r;
  logic [2:0]             beat_r;
  logic [YW-1:0]          row_r;
  logic [GW-1:0]          group_r;
  logic                   dirty_r;
  logic                   out_valid_r;
  out_beat_t              out_data_r;
  out_beat_t              out_data_nxt;

  logic signed [MAP_W-1:0] lx, ly, mx, my;
  logic                    map_ok;
  logic [AW-1:0]           pix_addr;
  logic [CW-1:0]           col0;
  logic [AW-1:0]           fl_base;
  logic [7:0]              mask;
  logic [7:0]              wr_byte;
  logic                    rd_bit;
  logic                    col_ok;
  logic                    last_pos;
  logic                    mem_we;
  logic [7:0]              mem_wdata;

  // rotation mapping
  always_comb begin
    lx = $signed(MAP_W'(item_r.pixel_x));
    ly = $signed(MAP_W'(item_r.pixel_y));
    unique case (orient_r)
      ROT_90: begin
        mx = ly;
        my = H_S - ONE_S - lx;
      end
      ROT_180: begin
        mx = W_S - ONE_S - lx;
        my = H_S - ONE_S - ly;
      end
      ROT_270: begin
        mx = H_S - ONE_S - ly;
        my = lx;
      end
      default: begin
        mx = lx;
        my = ly;
      end
    endcase
    map_ok = !mx[MAP_W-1] && (mx < W_S) && !my[MAP_W-1] && (my < H_S);
  end

  assign pix_addr = AW'(sy_r) * RB_A + AW'(sx_r[XW-1:3]);
  assign col0     = CW'(group_r) * THREE_C;
  assign fl_base  = AW'(row_r) * RB_A + AW'(col0);
  assign mask     = 8'h80 >> sx_r[2:0];
  assign wr_byte  = item_r.pixel_color ? (rdata_r | mask) : (rdata_r & ~mask);
  assign rd_bit   = ok_r & rdata_r[3'd7 - sx_r[2:0]];
  assign col_ok   = col_r < RB_C;
  assign last_pos = (row_r == LAST_ROW) && (group_r == LAST_GROUP);

  assign mem_we    = cmd.clr_step | cmd.mem_wr_pix;
  assign mem_wdata = cmd.clr_step ? 8'h00 : wr_byte;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_r] <= mem_wdata;
    end
    if (cmd.mem_rd) begin
      rdata_r <= mem[addr_r];
    end
  end

  // result beat
  always_comb begin
    out_data_nxt = '0;
    case (cmd.out_kind)
      OUT_READ: out_data_nxt.read_value = rd_bit;
      OUT_IDLE: out_data_nxt.flush_idle = 1'b1;
      OUT_BYTE: begin
        out_data_nxt.out_byte   = {bits_r[23], bits_r[23], 1'b0, bits_r[22], bits_r[22],
                                   1'b0, bits_r[21], bits_r[21]};
        out_data_nxt.group_last = (beat_r == 3'd7);
        out_data_nxt.frame_done = (beat_r == 3'd7) && last_pos;
      end
      default: out_data_nxt = '0;
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      item_r <= in_data;
    end
    if (cmd.do_map) begin
      sx_r <= mx[XW-1:0];
      sy_r <= my[YW-1:0];
      ok_r <= map_ok;
    end
    if (cmd.fl_addr) begin
      col_r  <= col0;
      bits_r <= '0;
    end else if (cmd.fl_take) begin
      col_r  <= col_r + CW'(1);
      bits_r <= {bits_r[15:0], col_ok ? rdata_r : 8'h00};
    end else if (cmd.out_load && cmd.out_kind == OUT_BYTE) begin
      bits_r <= {bits_r[20:0], 3'b000};
    end
    if (cmd.out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orient_r    <= ROT_0;
      addr_r      <= '0;
      fcnt_r      <= '0;
      beat_r      <= '0;
      row_r       <= '0;
      group_r     <= '0;
      dirty_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        orient_r <= cfg_wr_data;
      end
      if (cmd.do_addr) begin
        addr_r <= pix_addr;
      end else if (cmd.fl_addr) begin
        addr_r <= fl_base;
      end else if (cmd.fl_take || cmd.clr_step) begin
        addr_r <= addr_r + AW'(1);
      end
      if (cmd.fl_addr) begin
        fcnt_r <= '0;
        beat_r <= '0;
      end else begin
        if (cmd.fl_take) begin
          fcnt_r <= fcnt_r + 2'd1;
        end
        if (cmd.out_load && cmd.out_kind == OUT_BYTE) begin
          beat_r <= beat_r + 3'd1;
        end
      end
      if (cmd.mem_wr_pix) begin
        dirty_r <= 1'b1;
      end
      if (cmd.fl_advance) begin
        if (group_r == LAST_GROUP) begin
          group_r <= '0;
          if (row_r == LAST_ROW) begin
            row_r   <= '0;
            dirty_r <= 1'b0;
          end else begin
            row_r <= row_r + YW'(1);
          end
        end else begin
          group_r <= group_r + GW'(1);
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.action     = item_r.action;
  assign status.map_ok     = ok_r;
  assign status.dirty      = dirty_r;
  assign status.clr_last   = (addr_r == LAST_ADDR);
  assign status.out_free   = !out_valid_r || !out_stall;
  assign status.fetch_last = (fcnt_r == 2'd2);
  assign status.beat_last  = (beat_r == 3'd7);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while stalled");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_wr_pix |-> ok_r)
    else $error("pixel write for unmapped coordinate");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.frame_done) |-> out_data_r.group_last)
    else $error("frame_done without group_last");

  a_frame_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fl_advance && last_pos) |=> (!dirty_r && row_r == '0 && group_r == '0))
    else $error("flush position not rewound at frame end");

endmodule

// ===== hw/rtl/mfb_ctrl.sv =====
// ----------------------------------------------------------------------------
// mfb_ctrl
// sequencer for clearing, draw, read and flush operations
// ----------------------------------------------------------------------------
module mfb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mfb_pkg::dp_status_t  status,
  output mfb_pkg::dp_cmd_t     cmd
);
  import mfb_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MAP,
    S_CHK,
    S_FETCH,
    S_MODIFY,
    S_RESP,
    S_FL_ADDR,
    S_FL_READ,
    S_FL_TAKE,
    S_FL_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.out_kind = OUT_READ;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_item = 1'b1;
          state_nxt     = S_MAP;
        end
      end
      S_MAP: begin
        cmd.do_map = 1'b1;
        state_nxt  = S_CHK;
      end
      S_CHK: begin
        cmd.do_addr = 1'b1;
        unique case (status.action)
          ACT_DRAW:  state_nxt = status.map_ok ? S_FETCH : S_IDLE;
          ACT_READ:  state_nxt = status.map_ok ? S_FETCH : S_RESP;
          ACT_FLUSH: state_nxt = status.dirty ? S_FL_ADDR : S_RESP;
          default:   state_nxt = S_IDLE;
        endcase
      end
      S_FETCH: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = (status.action == ACT_DRAW) ? S_MODIFY : S_RESP;
      end
      S_MODIFY: begin
        cmd.mem_wr_pix = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_RESP: begin
        cmd.out_kind = (status.action == ACT_FLUSH) ? OUT_IDLE : OUT_READ;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_FL_ADDR: begin
        cmd.fl_addr = 1'b1;
        state_nxt   = S_FL_READ;
      end
      S_FL_READ: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_FL_TAKE;
      end
      S_FL_TAKE: begin
        cmd.fl_take = 1'b1;
        state_nxt   = status.fetch_last ? S_FL_EMIT : S_FL_READ;
      end
      S_FL_EMIT: begin
        cmd.out_kind = OUT_BYTE;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (status.beat_last) begin
            cmd.fl_advance = 1'b1;
            state_nxt      = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ===== hw/rtl/mono_framebuffer_rotate_pack_core.sv =====
// ----------------------------------------------------------------------------
// mono_framebuffer_rotate_pack_core
// one-bit frame store with rotated pixel access and packed gray flush
// ----------------------------------------------------------------------------
// steps: a draw is mapped, checked, fetched and written back; a read is mapped,
//   checked and fetched before its result is loaded (no fetch off-frame, nor for
//   the idle beat of a clean flush); a dirty flush fetches its three bytes, then
//   loads one byte a cycle while out_stall does not hold the result register
// throughput: one item at a time; a dirty flush step: three store reads, eight beats
// reset: synchronous active low; the store is cleared by a pass of one byte per
//   cycle over all ROW_BYTES * SCREEN_HEIGHT bytes (7200 by default), in_stall high
module mono_framebuffer_rotate_pack_core #(
  parameter int SCREEN_WIDTH  = mfb_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = mfb_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  mfb_pkg::in_beat_t             in_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output mfb_pkg::out_beat_t            out_data,
  // orientation register
  input  logic                          cfg_wr_en,
  input  logic [mfb_pkg::ORIENT_W-1:0]  cfg_wr_data
);
  import mfb_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: clear pass, per-action steps, flush fetch and beat emit
  mfb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: frame store, rotation map, flush unpack, result register
  // the result register parts the two channels, so a beat may wait on
  // out_stall while the next item is taken
  mfb_dp #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

// ===== dv/tb_mono_framebuffer_rotate_pack_core.sv =====
// ----------------------------------------------------------------------------
// tb_mono_framebuffer_rotate_pack_core
// self-checking bench for the rotated one-bit frame store and its gray flush
// ----------------------------------------------------------------------------
// keeps its own image of the frame, the flush position and the dirty mark,
// predicts every result beat from the accepted input beats and checks them
// in order; runs a directed pass, a run of flush steps under a long receiver
// hold-off and random phases under all four rotations with varying pacing
// ----------------------------------------------------------------------------
module tb_mono_framebuffer_rotate_pack_core;
  timeunit 1ns;
  timeprecision 1ps;

  import mfb_pkg::*;

  // frame geometry, matching the default build of the block
  localparam int FB_W        = SCREEN_WIDTH_DEF;
  localparam int FB_H        = SCREEN_HEIGHT_DEF;
  localparam int ROW_BYTES   = (FB_W + 7) / 8;
  localparam int ROW_GROUPS  = (ROW_BYTES + 2) / 3;
  localparam int STORE_BYTES = ROW_BYTES * FB_H;

  // margin for a draw still being written back into the store
  localparam int DRAIN_CYCLES = 16;
  // long receiver hold-off, long enough to back the block up
  localparam int BURST_LEN    = 300;
  // flush steps sent behind the long hold-off
  localparam int FLUSH_RUN    = 10;
  // quiet cycles before giving up; covers the clearing pass
  localparam int QUIET_LIMIT  = 40000;

  // illegal action code, the block must drop it
  localparam logic [1:0] ACT_NONE = 2'd3;

  typedef enum int {
    PACE_FULL,
    PACE_SEND_GAPS,
    PACE_RECV_STALL,
    PACE_BOTH
  } pace_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;
  logic      cfg_wr_en = 1'b0;
  logic [ORIENT_W-1:0] cfg_wr_data = '0;

  mono_framebuffer_rotate_pack_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // frame image and flush state, updated when an input beat is accepted
  // --------------------------------------------------------------------------
  logic [7:0]          frame_img [STORE_BYTES];
  logic [ORIENT_W-1:0] rot_model = ROT_0;
  bit                  frame_dirty_m = 1'b0;
  int                  flush_row_m = 0;
  int                  flush_grp_m = 0;

  in_beat_t  pixel_ops_q[$];    // beats waiting to be sent
  out_beat_t panel_beats_q[$];  // result beats still owed by the block

  pace_t pace = PACE_FULL;
  int    burst_req = 0;
  int    fail_cnt = 0;

  initial begin
    foreach (frame_img[i]) frame_img[i] = 8'h00;
  end

  // logical to stored coordinates; 0 when the pixel falls off the frame
  function automatic bit map_pixel(input int px, input int py, input logic [1:0] rot,
                                   output int sx, output int sy);
    case (rot)
      ROT_90: begin
        sx = py;
        sy = FB_H - 1 - px;
      end
      ROT_180: begin
        sx = FB_W - 1 - px;
        sy = FB_H - 1 - py;
      end
      ROT_270: begin
        sx = FB_H - 1 - py;
        sy = px;
      end
      default: begin
        sx = px;
        sy = py;
      end
    endcase
    return (sx >= 0 && sy >= 0 && sx < FB_W && sy < FB_H);
  endfunction

  // stored byte, zero past the end of a row
  function automatic logic [7:0] row_byte(input int row, input int col);
    if (row >= FB_H || col >= ROW_BYTES) return 8'h00;
    return frame_img[row * ROW_BYTES + col];
  endfunction

  // update the image and queue the beats that one input beat should cause
  task automatic predict_panel_beats(input in_beat_t item);
    int          sx, sy, idx;
    bit          hit, at_end;
    logic [7:0]  mask, pix;
    logic [23:0] bits;
    out_beat_t   beat;
    hit = map_pixel(int'(item.pixel_x), int'(item.pixel_y), rot_model, sx, sy);
    idx = sy * ROW_BYTES + (sx >> 3);
    mask = 8'h80 >> (sx & 7);
    beat = '0;
    case (item.action)
      ACT_DRAW: begin
        // off-frame draws leave the dirty mark alone
        if (hit) begin
          if (item.pixel_color) frame_img[idx] = frame_img[idx] | mask;
          else                  frame_img[idx] = frame_img[idx] & ~mask;
          frame_dirty_m = 1'b1;
        end
      end
      ACT_READ: begin
        if (hit) begin
          pix = frame_img[idx] & mask;
          beat.read_value = (pix != 8'h00);
        end
        panel_beats_q.push_back(beat);
      end
      ACT_FLUSH: begin
        if (!frame_dirty_m) begin
          // clean frame: one idle beat only
          beat.flush_idle = 1'b1;
          panel_beats_q.push_back(beat);
        end else begin
          bits = {row_byte(flush_row_m, flush_grp_m * 3),
                  row_byte(flush_row_m, flush_grp_m * 3 + 1),
                  row_byte(flush_row_m, flush_grp_m * 3 + 2)};
          at_end = (flush_row_m + 1 >= FB_H) && (flush_grp_m + 1 >= ROW_GROUPS);
          // three stored pixels per panel byte, each doubled
          for (int i = 0; i < 8; i++) begin
            beat = '0;
            if (bits[23]) beat.out_byte = beat.out_byte | 8'hC0;
            if (bits[22]) beat.out_byte = beat.out_byte | 8'h18;
            if (bits[21]) beat.out_byte = beat.out_byte | 8'h03;
            bits = bits << 3;
            beat.group_last = (i == 7);
            beat.frame_done = (i == 7) && at_end;
            panel_beats_q.push_back(beat);
          end
          flush_grp_m++;
          if (flush_grp_m >= ROW_GROUPS) begin
            flush_grp_m = 0;
            flush_row_m++;
            // wrap after exactly FB_H rows, frame becomes clean
            if (flush_row_m >= FB_H) begin
              flush_row_m = 0;
              frame_dirty_m = 1'b0;
            end
          end
        end
      end
      default: ;  // unknown action, nothing comes back
    endcase
  endtask

  // --------------------------------------------------------------------------
  // input driver: keeps valid and payload steady until the beat is taken
  // --------------------------------------------------------------------------
  function automatic bit sender_gap();
    case (pace)
      PACE_SEND_GAPS: return ($urandom_range(99) < 72);
      PACE_BOTH:      return ($urandom_range(99) < 12);
      default:        return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin
    logic     nxt_valid;
    in_beat_t nxt_data;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      nxt_data  = in_data;
      if (in_valid && !in_stall) begin
        predict_panel_beats(in_data);
        nxt_valid = 1'b0;
      end
      // back-to-back beats keep valid high, one assignment per edge
      if (!nxt_valid && pixel_ops_q.size() != 0 && !sender_gap()) begin
        nxt_valid = 1'b1;
        nxt_data  = pixel_ops_q.pop_front();
      end
      in_valid <= nxt_valid;
      in_data  <= nxt_data;
    end
  end

  // --------------------------------------------------------------------------
  // receiver: random stall plus a long hold-off on request
  // --------------------------------------------------------------------------
  function automatic bit recv_gap();
    case (pace)
      PACE_RECV_STALL: return ($urandom_range(99) < 72);
      PACE_BOTH:       return ($urandom_range(99) < 12);
      default:         return 1'b0;
    endcase
  endfunction

  int burst_ack = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (burst_req != burst_ack) begin
        burst_ack = burst_req;
        hold_left = BURST_LEN;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= recv_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // result monitor: in-order compare against the oldest owed beat
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (panel_beats_q.size() == 0) begin
        $error("unexpected result beat 0x%03h", out_data);
        fail_cnt++;
      end else begin
        want = panel_beats_q.pop_front();
        check_field("read_value", 8'(want.read_value), 8'(out_data.read_value));
        check_field("out_byte",   want.out_byte,       out_data.out_byte);
        check_field("group_last", 8'(want.group_last), 8'(out_data.group_last));
        check_field("frame_done", 8'(want.frame_done), 8'(out_data.frame_done));
        check_field("flush_idle", 8'(want.flush_idle), 8'(out_data.flush_idle));
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long without any beat moving on either side
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic in_beat_t mk_op(input logic [1:0] act, input int x, input int y,
                                     input bit color);
    in_beat_t op;
    op.action      = act;
    op.pixel_x     = x[8:0];
    op.pixel_y     = y[8:0];
    op.pixel_color = color;
    return op;
  endfunction

  // mostly inside the rotated frame size, sometimes edges or anything
  task automatic pick_xy(output int x, output int y);
    int  sel, xmax, ymax;
    bit  swap;
    swap = (rot_model == ROT_90 || rot_model == ROT_270);
    xmax = swap ? FB_H - 1 : FB_W - 1;
    ymax = swap ? FB_W - 1 : FB_H - 1;
    sel = $urandom_range(99);
    if (sel < 70) begin
      x = $urandom_range(xmax);
      y = $urandom_range(ymax);
    end else if (sel < 85) begin
      x = $urandom_range(1) ? xmax : 0;
      y = $urandom_range(1) ? ymax : 0;
    end else begin
      x = $urandom_range(511);
      y = $urandom_range(511);
    end
  endtask

  task automatic add_random_ops(input int n);
    int sel, x, y;
    repeat (n) begin
      sel = $urandom_range(99);
      pick_xy(x, y);
      if (sel < 30) begin
        // draw then read it back through the same rotation
        pixel_ops_q.push_back(mk_op(ACT_DRAW, x, y, 1'($urandom_range(1))));
        pixel_ops_q.push_back(mk_op(ACT_READ, x, y, 1'($urandom_range(1))));
      end else if (sel < 50) begin
        pixel_ops_q.push_back(mk_op(ACT_READ, x, y, 1'($urandom_range(1))));
      end else if (sel < 65) begin
        pixel_ops_q.push_back(mk_op(ACT_DRAW, x, y, 1'($urandom_range(1))));
      end else if (sel < 85) begin
        pixel_ops_q.push_back(mk_op(ACT_FLUSH, x, y, 1'($urandom_range(1))));
      end else if (sel < 94) begin
        pixel_ops_q.push_back(mk_op($urandom_range(1) ? ACT_DRAW : ACT_READ,
                                    $urandom_range(511), $urandom_range(511),
                                    1'($urandom_range(1))));
      end else begin
        pixel_ops_q.push_back(mk_op(ACT_NONE, $urandom_range(511), $urandom_range(511),
                                    1'($urandom_range(1))));
      end
    end
  endtask

  // sender holds back until every owed beat is back and the block is quiet
  task automatic wait_drained();
    do @(negedge clk);
    while (pixel_ops_q.size() != 0 || in_valid || panel_beats_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_orientation(input logic [ORIENT_W-1:0] rot);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= rot;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    rot_model = rot;
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed pass at the reset rotation
    pace = PACE_FULL;
    pixel_ops_q.push_back(mk_op(ACT_FLUSH, 0, 0, 1'b0));     // clean frame gives idle
    pixel_ops_q.push_back(mk_op(ACT_READ, 0, 0, 1'b0));
    pixel_ops_q.push_back(mk_op(ACT_DRAW, 0, 0, 1'b1));
    pixel_ops_q.push_back(mk_op(ACT_DRAW, FB_W - 1, FB_H - 1, 1'b1));
    pixel_ops_q.push_back(mk_op(ACT_DRAW, FB_W - 1, 0, 1'b1));
    pixel_ops_q.push_back(mk_op(ACT_DRAW, 511, 511, 1'b1));   // off-frame, dropped
    pixel_ops_q.push_back(mk_op(ACT_DRAW, FB_W, 0, 1'b1));    // one past the right edge
    pixel_ops_q.push_back(mk_op(ACT_READ, 0, 0, 1'b0));
    pixel_ops_q.push_back(mk_op(ACT_READ, FB_W - 1, FB_H - 1, 1'b0));
    pixel_ops_q.push_back(mk_op(ACT_READ, FB_W - 1, 0, 1'b1));
    pixel_ops_q.push_back(mk_op(ACT_READ, FB_W, 0, 1'b0));
    pixel_ops_q.push_back(mk_op(ACT_READ, 0, FB_H, 1'b0));
    pixel_ops_q.push_back(mk_op(ACT_READ, 511, 511, 1'b1));
    pixel_ops_q.push_back(mk_op(ACT_NONE, 511, 511, 1'b1));   // unknown action
    pixel_ops_q.push_back(mk_op(ACT_DRAW, 5, 0, 1'b1));
    pixel_ops_q.push_back(mk_op(ACT_DRAW, 5, 0, 1'b0));       // clear it again
    pixel_ops_q.push_back(mk_op(ACT_READ, 5, 0, 1'b0));
    pixel_ops_q.push_back(mk_op(ACT_FLUSH, 0, 0, 1'b0));      // first group of row 0
    pixel_ops_q.push_back(mk_op(ACT_DRAW, 2, 0, 1'b1));       // draw mid-flush
    pixel_ops_q.push_back(mk_op(ACT_FLUSH, 0, 0, 1'b0));
    pixel_ops_q.push_back(mk_op(ACT_READ, 2, 0, 1'b0));
    wait_drained();

    // run of flush steps under mild pacing, with a long receiver hold-off at
    // the start so the block fills and backs up its input
    pace = PACE_BOTH;
    pixel_ops_q.push_back(mk_op(ACT_DRAW, FB_W - 1, FB_H - 1, 1'b1));
    pixel_ops_q.push_back(mk_op(ACT_DRAW, FB_W - 8, FB_H - 1, 1'b1));
    pixel_ops_q.push_back(mk_op(ACT_DRAW, 100, 80, 1'b1));
    repeat (FLUSH_RUN) begin
      pixel_ops_q.push_back(mk_op(ACT_FLUSH, 0, 0, 1'b0));
      // occasional draws keep the flush position
      if ($urandom_range(99) < 8)
        pixel_ops_q.push_back(mk_op(ACT_DRAW, $urandom_range(FB_W - 1),
                                    $urandom_range(FB_H - 1), 1'($urandom_range(1))));
    end
    pixel_ops_q.push_back(mk_op(ACT_READ, FB_W - 1, FB_H - 1, 1'b0));
    burst_req++;
    wait_drained();

    // random phases, one per rotation and pacing
    set_orientation(ROT_90);
    pace = PACE_SEND_GAPS;
    add_random_ops(15);
    wait_drained();

    set_orientation(ROT_270);
    pace = PACE_RECV_STALL;
    add_random_ops(10);
    wait_drained();
    add_random_ops(10);
    wait_drained();

    set_orientation(ROT_180);
    pace = PACE_BOTH;
    add_random_ops(15);
    wait_drained();

    set_orientation(ROT_0);
    pace = PACE_FULL;
    add_random_ops(15);
    burst_req++;
    wait_drained();

    if (fail_cnt == 0 && panel_beats_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
